@@ rtl/angle_gyro_bias_kalman_filter_core_defines.svh @@
// Assertion macros used by the checker file of the angle/bias filter core.
// Needs the clk_i and rst_ni names to be visible where a macro is used.
`ifndef ANGLE_GYRO_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_GYRO_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define AGKF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("angle/bias filter assertion failed");

// Clocked assertion that also holds through reset.
`define AGKF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("angle/bias filter assertion failed");

`endif

@@ rtl/agkf_pkg.sv @@
// Shared types, constants and helpers for the angle/bias filter core.
// No dependencies; used by agkf_mul, agkf_div and the top level.
`default_nettype none

package agkf_pkg;

  localparam int unsigned AXES_DEF  = 3;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned AXIS_W    = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_Q  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DT = 2'd2;

  localparam logic [CFG_W-1:0] Q_RST  = 24'd33554;
  localparam logic [CFG_W-1:0] R_RST  = 24'd16777;
  localparam logic [CFG_W-1:0] DT_RST = 24'd41943;

  localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sh4000_0000;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_R_W = 36;
  localparam int unsigned SUM_W   = 38;

  typedef struct packed {
    logic                        start;
    logic                        gain;   // shift by 30 when set, by 24 otherwise
    logic signed [MUL_A_W-1:0]   a;
    logic signed [MUL_B_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                       start;
    logic signed [DATA_W-1:0]   num;
    logic        [DATA_W-1:0]   den;
  } div_req_t;

  localparam logic signed [SUM_W-1:0] S32_MAX_W = 38'sh00_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] S32_MIN_W = 38'sh3F_8000_0000;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/angle_gyro_bias_kalman_filter_core.sv @@
// An in-range item runs ten bit-serial products (32 multiplier bits each) and two gain
//   divisions (62 dividend bits each). Nonpositive innovation variance skips the gains
//   and the update products; an item with axis >= AXES skips all arithmetic.
// One item in flight: the next item is accepted only once the last result is registered.
// Reset (rst_ni low, asynchronous) loads the register reset values, zeros the angle and
//   bias slots and sets every covariance entry to 1.0 in Q2.30; no clearing pass.
`default_nettype none

module angle_gyro_bias_kalman_filter_core #(
  parameter int unsigned AXES = agkf_pkg::AXES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // axis[1:0], angle_meas[33:2], rate_meas[65:34]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // angle_est[31:0], bias_est[63:32]
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [agkf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [agkf_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned IW = (AXES > 1) ? $clog2(AXES) : 1;

  // Sequencer: predict products, innovation check, gains, update products, result
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;   // angle += (rate - bias) * dt
  localparam logic [3:0] ST_M1   = 4'd2;   // P00 += (Q - P01 - P10) * dt
  localparam logic [3:0] ST_M2   = 4'd3;   // P01, P10 += -P11 * dt
  localparam logic [3:0] ST_M3   = 4'd4;   // P11 += Q * dt
  localparam logic [3:0] ST_CHK  = 4'd5;   // S = P00 + R, innovation
  localparam logic [3:0] ST_D0   = 4'd6;   // K0 = P00 / S
  localparam logic [3:0] ST_D1   = 4'd7;   // K1 = P10 / S
  localparam logic [3:0] ST_U0   = 4'd8;   // angle += K0 * y
  localparam logic [3:0] ST_U1   = 4'd9;   // bias  += K1 * y
  localparam logic [3:0] ST_U2   = 4'd10;  // P10 -= K1 * P00
  localparam logic [3:0] ST_U3   = 4'd11;  // P00 -= K0 * P00
  localparam logic [3:0] ST_U4   = 4'd12;  // P11 -= K1 * P01
  localparam logic [3:0] ST_U5   = 4'd13;  // P01 -= K0 * P01
  localparam logic [3:0] ST_OUT  = 4'd14;

  typedef logic signed [31:0] s32_t;

  logic [3:0] state_q, state_d;
  logic       issued_q, issued_d;

  logic [agkf_pkg::CFG_W-1:0] q_cfg_q, r_cfg_q, dt_cfg_q;

  s32_t ang_arr_q  [AXES];
  s32_t bias_arr_q [AXES];
  s32_t p00_arr_q  [AXES];
  s32_t p01_arr_q  [AXES];
  s32_t p10_arr_q  [AXES];
  s32_t p11_arr_q  [AXES];

  // Working copy of one slot
  s32_t ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  s32_t z_q, rate_q, y_q, k0_q, k1_q;
  logic [31:0] s_q;
  logic        ax_ok_q;
  logic [IW-1:0] idx_q;

  logic        out_valid_q;
  s32_t        out_ang_q, out_bias_q;

  // Serial arithmetic units
  agkf_pkg::mul_req_t mul_req;
  agkf_pkg::div_req_t div_req;
  logic               mul_done, div_done;
  logic signed [agkf_pkg::MUL_R_W-1:0] mul_res;
  s32_t               div_quo;

  agkf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  agkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Input fields
  logic [3:0]    axis_ext;
  logic          in_ok;
  logic [IW-1:0] in_idx;
  logic          in_acc;

  assign axis_ext = {2'b00, s_axis_tdata[1:0]};
  assign in_ok    = axis_ext < 4'(AXES);
  assign in_idx   = axis_ext[IW-1:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Q and R in Q2.30
  logic [29:0] q30, r30;
  assign q30 = {q_cfg_q, 6'd0};
  assign r30 = {r_cfg_q, 6'd0};

  logic is_mul, is_div;
  assign is_mul = (state_q == ST_M0) || (state_q == ST_M1) || (state_q == ST_M2) ||
                  (state_q == ST_M3) || (state_q == ST_U0) || (state_q == ST_U1) ||
                  (state_q == ST_U2) || (state_q == ST_U3) || (state_q == ST_U4) ||
                  (state_q == ST_U5);
  assign is_div = (state_q == ST_D0) || (state_q == ST_D1);

  // Operand selection for the multiplier, and the value the product folds into
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_gain, mul_sub;
  s32_t               mul_base;

  always_comb begin
    mul_a    = 34'(ang_q);
    mul_b    = {9'd0, dt_cfg_q};
    mul_gain = 1'b0;
    mul_sub  = 1'b0;
    mul_base = ang_q;
    case (state_q)
      ST_M0: begin
        mul_a    = 34'(rate_q) - 34'(bias_q);
        mul_base = ang_q;
      end
      ST_M1: begin
        mul_a    = $signed({4'd0, q30}) - 34'(p01_q) - 34'(p10_q);
        mul_base = p00_q;
      end
      ST_M2: begin
        mul_a    = -34'(p11_q);
        mul_base = p01_q;
      end
      ST_M3: begin
        mul_a    = $signed({4'd0, q30});
        mul_base = p11_q;
      end
      ST_U0: begin
        mul_a = 34'(k0_q); mul_b = 33'(y_q); mul_gain = 1'b1; mul_base = ang_q;
      end
      ST_U1: begin
        mul_a = 34'(k1_q); mul_b = 33'(y_q); mul_gain = 1'b1; mul_base = bias_q;
      end
      ST_U2: begin
        mul_a = 34'(k1_q); mul_b = 33'(p00_q); mul_gain = 1'b1; mul_sub = 1'b1;
        mul_base = p10_q;
      end
      ST_U3: begin
        mul_a = 34'(k0_q); mul_b = 33'(p00_q); mul_gain = 1'b1; mul_sub = 1'b1;
        mul_base = p00_q;
      end
      ST_U4: begin
        mul_a = 34'(k1_q); mul_b = 33'(p01_q); mul_gain = 1'b1; mul_sub = 1'b1;
        mul_base = p11_q;
      end
      ST_U5: begin
        mul_a = 34'(k0_q); mul_b = 33'(p01_q); mul_gain = 1'b1; mul_sub = 1'b1;
        mul_base = p01_q;
      end
      default: begin
      end
    endcase
  end

  assign mul_req.start = is_mul && !issued_q;
  assign mul_req.gain  = mul_gain;
  assign mul_req.a     = mul_a;
  assign mul_req.b     = mul_b;

  assign div_req.start = is_div && !issued_q;
  assign div_req.num   = (state_q == ST_D1) ? p10_q : p00_q;
  assign div_req.den   = s_q;

  // Fold the finished product into its target, saturated
  s32_t upd, upd2;
  logic signed [agkf_pkg::SUM_W-1:0] base_w, res_w;
  assign base_w = agkf_pkg::SUM_W'(mul_base);
  assign res_w  = agkf_pkg::SUM_W'(mul_res);
  assign upd    = agkf_pkg::sat32(mul_sub ? (base_w - res_w) : (base_w + res_w));
  // P10 picks up the same -P11*dt term as P01
  assign upd2   = agkf_pkg::sat32(agkf_pkg::SUM_W'(p10_q) + res_w);

  // Innovation variance and innovation from the predicted values
  logic signed [33:0] s_w;
  logic               s_pos;
  s32_t               y_w;
  assign s_w   = 34'(p00_q) + $signed({4'd0, r30});
  assign s_pos = !s_w[33] && (s_w != '0);
  assign y_w   = agkf_pkg::sat32(agkf_pkg::SUM_W'(z_q) - agkf_pkg::SUM_W'(ang_q));

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    if ((is_mul && mul_req.start) || (is_div && div_req.start)) begin
      issued_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = in_ok ? ST_M0 : ST_OUT;
      ST_M0:   if (mul_done) begin state_d = ST_M1; issued_d = 1'b0; end
      ST_M1:   if (mul_done) begin state_d = ST_M2; issued_d = 1'b0; end
      ST_M2:   if (mul_done) begin state_d = ST_M3; issued_d = 1'b0; end
      ST_M3:   if (mul_done) begin state_d = ST_CHK; issued_d = 1'b0; end
      ST_CHK:  state_d = s_pos ? ST_D0 : ST_OUT;
      ST_D0:   if (div_done) begin state_d = ST_D1; issued_d = 1'b0; end
      ST_D1:   if (div_done) begin state_d = ST_U0; issued_d = 1'b0; end
      ST_U0:   if (mul_done) begin state_d = ST_U1; issued_d = 1'b0; end
      ST_U1:   if (mul_done) begin state_d = ST_U2; issued_d = 1'b0; end
      ST_U2:   if (mul_done) begin state_d = ST_U3; issued_d = 1'b0; end
      ST_U3:   if (mul_done) begin state_d = ST_U4; issued_d = 1'b0; end
      ST_U4:   if (mul_done) begin state_d = ST_U5; issued_d = 1'b0; end
      ST_U5:   if (mul_done) begin state_d = ST_OUT; issued_d = 1'b0; end
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cfg_q  <= agkf_pkg::Q_RST;
      r_cfg_q  <= agkf_pkg::R_RST;
      dt_cfg_q <= agkf_pkg::DT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        agkf_pkg::CFG_Q:  q_cfg_q  <= cfg_data_i;
        agkf_pkg::CFG_R:  r_cfg_q  <= cfg_data_i;
        agkf_pkg::CFG_DT: dt_cfg_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Working registers: load the slot, then advance through the step
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          z_q     <= s_axis_tdata[33:2];
          rate_q  <= s_axis_tdata[65:34];
          ax_ok_q <= in_ok;
          idx_q   <= in_idx;
          if (in_ok) begin
            ang_q  <= ang_arr_q[in_idx];
            bias_q <= bias_arr_q[in_idx];
            p00_q  <= p00_arr_q[in_idx];
            p01_q  <= p01_arr_q[in_idx];
            p10_q  <= p10_arr_q[in_idx];
            p11_q  <= p11_arr_q[in_idx];
          end else begin
            ang_q  <= '0;
            bias_q <= '0;
          end
        end
      end
      ST_M0, ST_U0: if (mul_done) ang_q <= upd;
      ST_M1, ST_U3: if (mul_done) p00_q <= upd;
      ST_M2: begin
        if (mul_done) begin
          p01_q <= upd;
          p10_q <= upd2;
        end
      end
      ST_M3, ST_U4: if (mul_done) p11_q <= upd;
      ST_CHK: begin
        s_q <= s_w[31:0];
        y_q <= y_w;
      end
      ST_D0: if (div_done) k0_q <= div_quo;
      ST_D1: if (div_done) k1_q <= div_quo;
      ST_U1: if (mul_done) bias_q <= upd;
      ST_U2: if (mul_done) p10_q <= upd;
      ST_U5: if (mul_done) p01_q <= upd;
      default: begin
      end
    endcase
  end

  // Per-axis state: write back when the result leaves the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        ang_arr_q[i]  <= '0;
        bias_arr_q[i] <= '0;
        p00_arr_q[i]  <= agkf_pkg::ONE_Q30;
        p01_arr_q[i]  <= agkf_pkg::ONE_Q30;
        p10_arr_q[i]  <= agkf_pkg::ONE_Q30;
        p11_arr_q[i]  <= agkf_pkg::ONE_Q30;
      end
    end else if ((state_q == ST_OUT) && out_free && ax_ok_q) begin
      ang_arr_q[idx_q]  <= ang_q;
      bias_arr_q[idx_q] <= bias_q;
      p00_arr_q[idx_q]  <= p00_q;
      p01_arr_q[idx_q]  <= p01_q;
      p10_arr_q[idx_q]  <= p10_q;
      p11_arr_q[idx_q]  <= p11_q;
    end
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_ang_q  <= ang_q;
      out_bias_q <= bias_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_bias_q, out_ang_q};
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

@@ rtl/agkf_mul.sv @@
// Bit-serial signed multiplier with round-half-away right shift by 24 or 30.
// Depends on agkf_pkg.
`default_nettype none

module agkf_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire agkf_pkg::mul_req_t                   req_i,
  output logic                                      done_o,
  output logic signed [agkf_pkg::MUL_R_W-1:0]       res_o
);

  localparam int unsigned AW = agkf_pkg::MUL_A_W;
  localparam int unsigned PW = AW + 32;

  logic          busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [AW-1:0] ma_q, ma_d;
  logic [31:0]   mb_q, mb_d;
  logic [PW-1:0] p_q, p_d;
  logic          neg_q, neg_d, gain_q, gain_d;
  logic signed [agkf_pkg::MUL_R_W-1:0] res_q, res_d;

  logic [AW:0]   step_sum;
  logic [agkf_pkg::MUL_R_W-1:0] mag;
  logic [AW-1:0] abs_a;
  logic [agkf_pkg::MUL_B_W-1:0] abs_b;

  assign abs_a    = req_i.a[AW-1] ? AW'(-req_i.a) : AW'(req_i.a);
  assign abs_b    = req_i.b[agkf_pkg::MUL_B_W-1] ? agkf_pkg::MUL_B_W'(-req_i.b)
                                                 : agkf_pkg::MUL_B_W'(req_i.b);
  // Add the multiplicand into the upper half when the current multiplier bit is set
  assign step_sum = {1'b0, p_q[PW-1:32]} + (mb_q[0] ? {1'b0, ma_q} : '0);
  assign mag      = gain_q ? (p_q[65:30] + {35'd0, p_q[29]})
                           : (p_q[59:24] + {35'd0, p_q[23]});

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    p_d    = p_q;
    neg_d  = neg_q;
    gain_d = gain_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ma_d   = abs_a;
      mb_d   = abs_b[31:0];
      p_d    = '0;
      neg_d  = req_i.a[AW-1] ^ req_i.b[agkf_pkg::MUL_B_W-1];
      gain_d = req_i.gain;
    end else if (busy_q) begin
      p_d   = {step_sum, p_q[31:1]};
      mb_d  = {1'b0, mb_q[31:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      res_d  = neg_q ? -$signed(mag) : $signed(mag);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    p_q    <= p_d;
    neg_q  <= neg_d;
    gain_q <= gain_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/agkf_div.sv @@
// Bit-serial restoring divider for gains: sat32((num * 2^30) / den), den > 0.
// Depends on agkf_pkg.
`default_nettype none

module agkf_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire agkf_pkg::div_req_t                  req_i,
  output logic                                     done_o,
  output logic signed [agkf_pkg::DATA_W-1:0]       quo_o
);

  localparam int unsigned DW = 62;

  logic          busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [DW-1:0] dd_q, dd_d;
  logic [31:0]   den_q, den_d, rem_q, rem_d;
  logic [32:0]   qt_q, qt_d;
  logic          ovf_q, ovf_d, neg_q, neg_d;
  logic signed [31:0] quo_q, quo_d;

  logic [32:0] sh;
  logic        fits;
  logic [31:0] abs_num;
  logic        big;

  assign abs_num = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
  assign sh      = {rem_q, dd_q[DW-1]};
  assign fits    = sh >= {1'b0, den_q};
  assign big     = ovf_q | qt_q[32];

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dd_d   = dd_q;
    den_d  = den_q;
    rem_d  = rem_q;
    qt_d   = qt_q;
    ovf_d  = ovf_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dd_d   = {abs_num, 30'd0};
      den_d  = req_i.den;
      rem_d  = '0;
      qt_d   = '0;
      ovf_d  = 1'b0;
      neg_d  = req_i.num[31];
    end else if (busy_q) begin
      rem_d = fits ? 32'(sh - {1'b0, den_q}) : sh[31:0];
      dd_d  = {dd_q[DW-2:0], 1'b0};
      qt_d  = {qt_q[31:0], fits};
      ovf_d = ovf_q | qt_q[32];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DW - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      done_d = 1'b1;
      if (neg_q) begin
        if (big || (qt_q[31:0] > 32'h8000_0000)) begin
          quo_d = 32'sh8000_0000;
        end else begin
          quo_d = -$signed(qt_q[31:0]);
        end
      end else begin
        if (big || qt_q[31]) begin
          quo_d = 32'sh7FFF_FFFF;
        end else begin
          quo_d = $signed(qt_q[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q  <= dd_d;
    den_q <= den_d;
    rem_q <= rem_d;
    qt_q  <= qt_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/agkf_checker.sv @@
// Port-level checks for the angle/bias filter core, bound to the top level.
// Depends on angle_gyro_bias_kalman_filter_core_defines.svh.
`default_nettype none

`include "angle_gyro_bias_kalman_filter_core_defines.svh"

module agkf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        cfg_ready_o
);

  `AGKF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `AGKF_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `AGKF_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `AGKF_ASSERT(a_no_instant_result, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
  `AGKF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid && cfg_ready_o)

endmodule

bind angle_gyro_bias_kalman_filter_core agkf_checker u_agkf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire
